// ----- rtl/bbs_pkg.sv -----
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared types and constants of the bouncing body step: opcodes, result
// kinds, register indexes, channel words and register reset values.
// ----------------------------------------------------------------------------
package bbs_pkg;

   // field widths fixed by the channel words
   localparam int FIELD_WIDTH    = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REST_WIDTH     = 17;
   localparam int SHORT_WIDTH    = 16;

   typedef enum logic {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FLOOR_HEIGHT = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RESTITUTION  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRAVITY_DV   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRAVITY_DZ   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TIME_STEP    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HOLD_TICKS   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RECORD_TICKS = 3'd6;

   // register reset values
   localparam logic signed [FIELD_WIDTH-1:0] FLOOR_HEIGHT_RESET = 32'sd0;
   localparam logic [REST_WIDTH-1:0]         RESTITUTION_RESET  = 17'd52429;
   localparam logic signed [FIELD_WIDTH-1:0] GRAVITY_DV_RESET   = -32'sd6423;
   localparam logic signed [FIELD_WIDTH-1:0] GRAVITY_DZ_RESET   = -32'sd32;
   localparam logic [SHORT_WIDTH-1:0]        TIME_STEP_RESET    = 16'd655;
   localparam logic [SHORT_WIDTH-1:0]        HOLD_TICKS_RESET   = 16'd0;
   localparam logic [SHORT_WIDTH-1:0]        RECORD_TICKS_RESET = 16'd1;

   typedef struct packed {
      opcode_type                     opcode;
      logic signed [FIELD_WIDTH-1:0]  init_x;
      logic signed [FIELD_WIDTH-1:0]  init_y;
      logic signed [FIELD_WIDTH-1:0]  init_z;
      logic signed [FIELD_WIDTH-1:0]  init_vx;
      logic signed [FIELD_WIDTH-1:0]  init_vy;
      logic signed [FIELD_WIDTH-1:0]  init_vz;
   } req_word_type;

   typedef struct packed {
      kind_type                       kind;
      logic signed [FIELD_WIDTH-1:0]  pos_x;
      logic signed [FIELD_WIDTH-1:0]  pos_y;
      logic signed [FIELD_WIDTH-1:0]  pos_z;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_INDEX_WIDTH-1:0]     index;
      logic [CSR_DATA_WIDTH-1:0]      wdata;
   } csr_word_type;

endpackage

// ----- rtl/bbs_chan_if.sv -----
// ----------------------------------------------------------------------------
// bbs_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface bbs_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/bouncing_body_step.sv -----
// ----------------------------------------------------------------------------
// bouncing_body_step
// Fixed-point Euler projectile with a damped floor bounce, one word a cycle unless rsp_if stalls.
// ----------------------------------------------------------------------------
// Usage
//   req_if : input words, opcode start (loads position and velocity) or tick.
//   rsp_if : result words; a start always answers accepted or rejected, a
//            tick while running answers with a position sample when the
//            record counter is due, otherwise it gives no word.
//   csr_if : register writes (index, data), always ready; write only while
//            no input word is in flight.
//   A word is captured in the input register at the req_if handshake and the
//   update logic loads the result register from it, so a result passes the
//   input register and then the result register before rsp_if valid. One word
//   is taken every cycle while rsp_if is not stalled; the whole state update
//   (four value-by-17-bit multiplies, saturating adds) is combinational
//   between the two registers.
//   When rsp_if stalls, the result register holds its word and the input
//   register fills; req_if.ready then follows rsp_if.ready.
//   Reset clears position, velocity, counters and the running flag and
//   loads the register reset values. Values are Q16.16, kept internally at
//   VALUE_WIDTH bits with saturation.
// ----------------------------------------------------------------------------
module bouncing_body_step #(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   bbs_chan_if.sink   req_if,
   bbs_chan_if.source rsp_if,
   bbs_chan_if.sink   csr_if
);
   import bbs_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int CW = COUNT_WIDTH;
   localparam int SW = W + 33;

   localparam logic signed [W-1:0]  VMAX_W   = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  VMIN_W   = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [SW-1:0] VMAX_EXT = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] VMIN_EXT = ~VMAX_EXT;

   // saturate a wide signed value to the value range
   function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] x);
      logic signed [W-1:0] r;
      if (x > VMAX_EXT) begin
         r = VMAX_W;
      end else if (x < VMIN_EXT) begin
         r = VMIN_W;
      end else begin
         r = x[W-1:0];
      end
      return r;
   endfunction

   // floor(a*b/2^16), saturated; a high part below the range saturates early
   function automatic logic signed [W-1:0] mul_q16(input logic signed [W-1:0] a,
                                                   input logic [REST_WIDTH-1:0] b);
      logic signed [W-1:0]  hi;
      logic [15:0]          lo;
      logic signed [W+18:0] hb;
      logic [32:0]          lb;
      logic signed [SW-1:0] sum;
      logic signed [W-1:0]  r;
      hi  = a >>> 16;
      lo  = a[15:0];
      hb  = hi * $signed({1'b0, b});
      lb  = 33'(lo) * 33'(b);
      sum = SW'(hb) + SW'($signed({1'b0, lb[32:16]}));
      if (SW'(hb) < VMIN_EXT) begin
         r = VMIN_W;
      end else begin
         r = sat_w(sum);
      end
      return r;
   endfunction

   // saturating add of two in-range values
   function automatic logic signed [W-1:0] add_w(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
      return sat_w(SW'(a) + SW'(b));
   endfunction

   // low 32 bits of the sign-extended value
   function automatic logic signed [FIELD_WIDTH-1:0] low32(input logic signed [W-1:0] v);
      logic signed [W+31:0] t;
      t = (W+32)'(v);
      return t[FIELD_WIDTH-1:0];
   endfunction

   // counter load, saturated to the counter width
   function automatic logic [CW-1:0] cnt_load(input logic [SHORT_WIDTH-1:0] v);
      logic [CW+15:0] t;
      t = (CW+16)'(v);
      if (t > (CW+16)'({CW{1'b1}})) begin
         t = (CW+16)'({CW{1'b1}});
      end
      return t[CW-1:0];
   endfunction

   // configuration registers
   logic signed [FIELD_WIDTH-1:0] floor_ff;
   logic [REST_WIDTH-1:0]         rest_ff;
   logic signed [FIELD_WIDTH-1:0] gdv_ff;
   logic signed [FIELD_WIDTH-1:0] gdz_ff;
   logic [SHORT_WIDTH-1:0]        tstep_ff;
   logic [SHORT_WIDTH-1:0]        hold_ticks_ff;
   logic [SHORT_WIDTH-1:0]        rec_ticks_ff;

   // body state
   logic signed [W-1:0] pos_ff [3];
   logic signed [W-1:0] pos_in [3];
   logic signed [W-1:0] vel_ff [3];
   logic signed [W-1:0] vel_in [3];
   logic [CW-1:0]       hold_cnt_ff, hold_cnt_in;
   logic [CW-1:0]       rec_cnt_ff, rec_cnt_in;
   logic                running_ff, running_in;

   // input register and result register
   logic         stage_valid_ff;
   req_word_type stage_word_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         has_result;

   logic out_free, fire, req_fire;
   logic signed [W-1:0] flr;
   logic signed [W-1:0] init_pos [3];
   logic signed [W-1:0] init_vel [3];
   logic signed [W-1:0] bounce_p;
   logic signed [W-1:0] gdv_w, gdz_w;
   logic [SHORT_WIDTH-1:0] rec_eff;
   logic bounce;

   // handshakes
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign fire          = stage_valid_ff && out_free;
   assign req_if.ready  = !stage_valid_ff || fire;
   assign req_fire      = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.data   = rsp_word_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff      <= FLOOR_HEIGHT_RESET;
         rest_ff       <= RESTITUTION_RESET;
         gdv_ff        <= GRAVITY_DV_RESET;
         gdz_ff        <= GRAVITY_DZ_RESET;
         tstep_ff      <= TIME_STEP_RESET;
         hold_ticks_ff <= HOLD_TICKS_RESET;
         rec_ticks_ff  <= RECORD_TICKS_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.data.index)
            REG_FLOOR_HEIGHT: floor_ff      <= $signed(csr_if.data.wdata);
            REG_RESTITUTION:  rest_ff       <= csr_if.data.wdata[REST_WIDTH-1:0];
            REG_GRAVITY_DV:   gdv_ff        <= $signed(csr_if.data.wdata);
            REG_GRAVITY_DZ:   gdz_ff        <= $signed(csr_if.data.wdata);
            REG_TIME_STEP:    tstep_ff      <= csr_if.data.wdata[SHORT_WIDTH-1:0];
            REG_HOLD_TICKS:   hold_ticks_ff <= csr_if.data.wdata[SHORT_WIDTH-1:0];
            REG_RECORD_TICKS: rec_ticks_ff  <= csr_if.data.wdata[SHORT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_fire) begin
         stage_valid_ff <= 1'b1;
      end else if (fire) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_word_ff <= req_if.data;
      end
   end

   // operands brought into the value range
   assign flr   = sat_w(SW'($signed(floor_ff)));
   assign gdv_w = sat_w(SW'($signed(gdv_ff)));
   assign gdz_w = sat_w(SW'($signed(gdz_ff)));
   assign init_pos[0] = sat_w(SW'($signed(stage_word_ff.init_x)));
   assign init_pos[1] = sat_w(SW'($signed(stage_word_ff.init_y)));
   assign init_pos[2] = sat_w(SW'($signed(stage_word_ff.init_z)));
   assign init_vel[0] = sat_w(SW'($signed(stage_word_ff.init_vx)));
   assign init_vel[1] = sat_w(SW'($signed(stage_word_ff.init_vy)));
   assign init_vel[2] = sat_w(SW'($signed(stage_word_ff.init_vz)));
   assign bounce_p    = mul_q16(vel_ff[2], rest_ff);
   assign rec_eff     = (rec_ticks_ff == '0) ? SHORT_WIDTH'(1) : rec_ticks_ff;

   // state update and result for the word in the input register
   always_comb begin
      pos_in      = pos_ff;
      vel_in      = vel_ff;
      hold_cnt_in = hold_cnt_ff;
      rec_cnt_in  = rec_cnt_ff;
      running_in  = running_ff;
      has_result  = 1'b0;
      bounce      = 1'b0;
      rsp_word_in = '{kind: KIND_SAMPLE, pos_x: '0, pos_y: '0, pos_z: '0};
      if (stage_word_ff.opcode == OP_START) begin
         has_result = 1'b1;
         if (init_pos[2] < flr) begin
            running_in       = 1'b0;
            rsp_word_in.kind = KIND_REJECT;
         end else begin
            pos_in           = init_pos;
            vel_in           = init_vel;
            hold_cnt_in      = '0;
            rec_cnt_in       = '0;
            running_in       = 1'b1;
            rsp_word_in.kind = KIND_ACCEPT;
         end
      end else if (running_ff) begin
         // sample when the record counter is due
         if (rec_cnt_ff == '0) begin
            has_result        = 1'b1;
            rsp_word_in.pos_x = low32(pos_ff[0]);
            rsp_word_in.pos_y = low32(pos_ff[1]);
            rsp_word_in.pos_z = low32(pos_ff[2]);
            rec_cnt_in        = cnt_load(rec_eff - SHORT_WIDTH'(1));
         end else begin
            rec_cnt_in = rec_cnt_ff - CW'(1);
         end
         // rebound hold, bounce or Euler step
         if (hold_cnt_ff != '0) begin
            hold_cnt_in = hold_cnt_ff - CW'(1);
         end else if (pos_ff[2] < flr) begin
            bounce      = 1'b1;
            pos_in[2]   = flr;
            vel_in[2]   = (bounce_p == VMIN_W) ? VMAX_W : -bounce_p;
            hold_cnt_in = cnt_load(hold_ticks_ff);
         end else begin
            pos_in[0] = add_w(pos_ff[0], mul_q16(vel_ff[0], {1'b0, tstep_ff}));
            pos_in[1] = add_w(pos_ff[1], mul_q16(vel_ff[1], {1'b0, tstep_ff}));
            pos_in[2] = add_w(add_w(pos_ff[2], mul_q16(vel_ff[2], {1'b0, tstep_ff})),
                              gdz_w);
            vel_in[2] = add_w(vel_ff[2], gdv_w);
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '{default: '0};
         vel_ff      <= '{default: '0};
         hold_cnt_ff <= '0;
         rec_cnt_ff  <= '0;
         running_ff  <= 1'b0;
      end else if (fire) begin
         pos_ff      <= pos_in;
         vel_ff      <= vel_in;
         hold_cnt_ff <= hold_cnt_in;
         rec_cnt_ff  <= rec_cnt_in;
         running_ff  <= running_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= has_result;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && has_result) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // checks
   a_rsp_from_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire))
      else $error("result word appeared without an update");

   a_bounce_on_floor: assert property (@(posedge clock) disable iff (reset)
      (fire && bounce) |=> (pos_ff[2] == $past(flr)))
      else $error("bounce did not place z on the floor");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && stage_word_ff.opcode == OP_START && !(init_pos[2] < flr)) |=>
      (running_ff && hold_cnt_ff == '0 && rec_cnt_ff == '0))
      else $error("accepted start did not set up the run");

endmodule
